// ----- sv/silence_trim_fade_gain_macros.svh -----
// ----------------------------------------------------------------------------
// silence_trim_fade_gain assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SILENCE_TRIM_FADE_GAIN_MACROS_SVH
`define SILENCE_TRIM_FADE_GAIN_MACROS_SVH

// property checked only while out of reset
`define STF_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// property checked at every edge, reset included
`define STF_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/stf_pkg.sv -----
// ----------------------------------------------------------------------------
// stf_pkg
// types, constants and register codes of the silence trim / fade / gain block
// ----------------------------------------------------------------------------
`default_nettype none

package stf_pkg;

    localparam int POSITION_WIDTH = 32;
    localparam int FRAME_W        = 32;
    localparam int CMP_WIDTH      = (POSITION_WIDTH > FRAME_W) ? POSITION_WIDTH : FRAME_W;

    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 16;
    localparam int SCAN_W     = 24;
    localparam int VOL_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // lane datapath widths
    localparam int GAIN_W    = SAMPLE_W + VOL_W;
    localparam int PROD_W    = GAIN_W + FRAME_W;
    localparam int QUO_W     = 19;
    localparam int REM_W     = FRAME_W + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = 5;
    localparam int Q_FRAC    = 12;

    localparam logic [QUO_W-1:0] SAT_POS     = QUO_W'(32767);
    localparam logic [QUO_W-1:0] SAT_NEG_MAG = QUO_W'(32768);

    // reset values of the registers
    localparam logic [THR_W-1:0]   RST_THRESHOLD  = THR_W'(8);
    localparam logic [SCAN_W-1:0]  RST_SCAN_LIMIT = SCAN_W'(441000);
    localparam logic [FRAME_W-1:0] RST_FADE_START = FRAME_W'(6615000);
    localparam logic [FRAME_W-1:0] RST_TOTAL      = FRAME_W'(6967800);
    localparam logic [VOL_W-1:0]   RST_VOLUME     = VOL_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SILENCE_THRESHOLD = 3'd0,
        REG_SCAN_LIMIT        = 3'd1,
        REG_FADE_START        = 3'd2,
        REG_TOTAL_FRAMES      = 3'd3,
        REG_VOLUME_Q12        = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } in_frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       end_of_track;
    } out_frame_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_GAIN,
        L_MUL,
        L_PREP,
        L_DIV,
        L_DONE
    } lane_state_t;

    typedef enum logic {
        C_IDLE,
        C_BUSY
    } ctl_state_t;

    typedef struct packed {
        logic start;
        logic fading;
        logic ack;
    } lane_ctrl_t;

    typedef struct packed {
        logic done;
    } lane_stat_t;

endpackage

`default_nettype wire

// ----- sv/silence_trim_fade_gain.sv -----
// a kept frame holds off the next input until both lanes finish and the output register
//   can take its result; inside the fade each lane also runs its 19-step restoring
//   divider; a trimmed or dropped frame is taken without holding off the next one
// reset: synchronous active-low aresetn restores register defaults, restarts the
//   silence search and sets the output position to zero
// ----------------------------------------------------------------------------
// silence_trim_fade_gain
// leading-silence trimmer with Q4.12 gain and linear fade-out for stereo frames
// ----------------------------------------------------------------------------
`default_nettype none

module silence_trim_fade_gain
    import stf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input frames
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_frame_t             s_data,
    // result frames
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_frame_t                 m_data
);

    // configuration registers
    logic [THR_W-1:0]   thr_reg;
    logic [SCAN_W-1:0]  scan_limit_reg;
    logic [FRAME_W-1:0] fade_start_reg;
    logic [FRAME_W-1:0] total_reg;
    logic [VOL_W-1:0]   vol_reg;

    // trimming and position state
    logic                       trimming_reg, trimming_next;
    logic [SAMPLE_W-1:0]        prev_l_reg, prev_l_next;
    logic [SAMPLE_W-1:0]        prev_r_reg, prev_r_next;
    logic [SCAN_W-1:0]          scanned_reg, scanned_next;
    logic [POSITION_WIDTH-1:0]  pos_reg, pos_next;
    logic                       eot_reg;

    ctl_state_t state_reg, state_next;

    logic accept;
    logic loud;
    logic trim_drop;
    logic ended;
    logic keep;

    logic signed [SAMPLE_W:0] diff_l, diff_r;
    logic [SAMPLE_W:0]        adiff_l, adiff_r;

    logic [CMP_WIDTH-1:0] pos_ext, total_ext, fade_ext;
    logic [CMP_WIDTH-1:0] num_full;
    logic [FRAME_W-1:0]   num, den;
    logic                 fading;
    logic                 last_frame;

    lane_ctrl_t lane_ctrl;
    lane_stat_t left_stat, right_stat;
    logic signed [SAMPLE_W-1:0] left_res, right_res;
    logic lanes_done, out_free;

    assign accept = s_valid && s_ready;

    // per-channel change against the previous trimmed frame
    assign diff_l  = {s_data.left_in[SAMPLE_W-1], s_data.left_in}
                   - {prev_l_reg[SAMPLE_W-1], prev_l_reg};
    assign diff_r  = {s_data.right_in[SAMPLE_W-1], s_data.right_in}
                   - {prev_r_reg[SAMPLE_W-1], prev_r_reg};
    assign adiff_l = diff_l[SAMPLE_W] ? (SAMPLE_W+1)'(-diff_l) : diff_l;
    assign adiff_r = diff_r[SAMPLE_W] ? (SAMPLE_W+1)'(-diff_r) : diff_r;

    // scan exhausted or loud frame ends the search; kept unless the track has ended
    assign loud = (scanned_reg >= scan_limit_reg)
               || (adiff_l > {1'b0, thr_reg})
               || (adiff_r > {1'b0, thr_reg});
    assign trim_drop = trimming_reg && !loud;

    // position compares, widened so any position width works
    assign pos_ext    = CMP_WIDTH'(pos_reg);
    assign total_ext  = CMP_WIDTH'(total_reg);
    assign fade_ext   = CMP_WIDTH'(fade_start_reg);
    assign ended      = (pos_ext >= total_ext);
    assign keep       = !trim_drop && !ended;
    assign fading     = (total_ext > fade_ext) && (pos_ext > fade_ext);
    assign last_frame = ({1'b0, pos_ext} + (CMP_WIDTH+1)'(1)) == {1'b0, total_ext};

    // frames remaining and fade length; position is below total when kept
    assign num_full = total_ext - pos_ext;
    assign num      = num_full[FRAME_W-1:0];
    assign den      = total_reg - fade_start_reg;

    // config write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= RST_THRESHOLD;
            scan_limit_reg <= RST_SCAN_LIMIT;
            fade_start_reg <= RST_FADE_START;
            total_reg      <= RST_TOTAL;
            vol_reg        <= RST_VOLUME;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SILENCE_THRESHOLD: thr_reg        <= cfg_wdata[THR_W-1:0];
                REG_SCAN_LIMIT:        scan_limit_reg <= cfg_wdata[SCAN_W-1:0];
                REG_FADE_START:        fade_start_reg <= cfg_wdata[FRAME_W-1:0];
                REG_TOTAL_FRAMES:      total_reg      <= cfg_wdata[FRAME_W-1:0];
                REG_VOLUME_Q12:        vol_reg        <= cfg_wdata[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    // trimming, history and position updates on each input transfer
    always_comb begin
        trimming_next = trimming_reg;
        prev_l_next   = prev_l_reg;
        prev_r_next   = prev_r_reg;
        scanned_next  = scanned_reg;
        pos_next      = pos_reg;
        if (accept) begin
            if (trim_drop) begin
                prev_l_next  = s_data.left_in;
                prev_r_next  = s_data.right_in;
                scanned_next = scanned_reg + SCAN_W'(1);
            end else begin
                trimming_next = 1'b0;
                if (!ended) begin
                    pos_next = pos_reg + POSITION_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trimming_reg <= 1'b1;
            prev_l_reg   <= '0;
            prev_r_reg   <= '0;
            scanned_reg  <= '0;
            pos_reg      <= '0;
        end else begin
            trimming_reg <= trimming_next;
            prev_l_reg   <= prev_l_next;
            prev_r_reg   <= prev_r_next;
            scanned_reg  <= scanned_next;
            pos_reg      <= pos_next;
        end
    end

    // end flag rides along with the frame in flight
    always_ff @(posedge aclk) begin
        if (accept && keep) begin
            eot_reg <= last_frame;
        end
    end

    // control: idle takes frames, busy waits for the lanes to hand off
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (accept && keep) state_next = C_BUSY;
            C_BUSY: if (lanes_done && out_free) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == C_IDLE);
        lane_ctrl.start  = accept && keep;
        lane_ctrl.fading = fading;
        lane_ctrl.ack    = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // one lane per channel, same schedule
    stf_lane u_lane_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lane_ctrl),
        .sample_in (s_data.left_in),
        .volume    (vol_reg),
        .num       (num),
        .den       (den),
        .stat      (left_stat),
        .result    (left_res)
    );

    stf_lane u_lane_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lane_ctrl),
        .sample_in (s_data.right_in),
        .volume    (vol_reg),
        .num       (num),
        .den       (den),
        .stat      (right_stat),
        .result    (right_res)
    );

    // output register: lanes can finish while an older result waits
    stf_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .left_stat  (left_stat),
        .right_stat (right_stat),
        .left_res   (left_res),
        .right_res  (right_res),
        .eot        (eot_reg),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_data     (m_data),
        .done       (lanes_done),
        .free       (out_free)
    );

endmodule

`default_nettype wire

// ----- sv/stf_lane.sv -----
// ----------------------------------------------------------------------------
// stf_lane
// one channel: gain multiply, then in the fade a fade multiply and restoring divide; saturation
// ----------------------------------------------------------------------------
`default_nettype none

module stf_lane
    import stf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic [VOL_W-1:0]           volume,
    input  wire logic [FRAME_W-1:0]         num,
    input  wire logic [FRAME_W-1:0]         den,
    output lane_stat_t                      stat,
    output logic signed [SAMPLE_W-1:0]      result
);

    lane_state_t state_reg, state_next;

    logic                neg_reg;
    logic [SAMPLE_W-1:0] mag_reg;
    logic [VOL_W-1:0]    vol_reg;
    logic [FRAME_W-1:0]  num_reg;
    logic [FRAME_W-1:0]  den_reg;
    logic                fading_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [QUO_W-1:0]    dvd_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [SAMPLE_W-1:0] sample_u;
    logic [SAMPLE_W-1:0] mag;
    logic [REM_W-1:0]    cand;
    logic                fits;
    logic [QUO_W-1:0]    q_sat;

    assign sample_u = sample_in;
    assign mag      = sample_u[SAMPLE_W-1] ? (~sample_u + SAMPLE_W'(1)) : sample_u;

    // one quotient bit per step
    assign cand = {rem_reg[REM_W-2:0], dvd_reg[QUO_W-1]};
    assign fits = (cand >= {1'b0, den_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE: if (ctrl.start) state_next = L_GAIN;
            L_GAIN: state_next = L_MUL;
            L_MUL:  state_next = fading_reg ? L_PREP : L_DONE;
            L_PREP: state_next = L_DIV;
            L_DIV:  if (cnt_reg == '0) state_next = L_DONE;
            L_DONE: if (ctrl.ack) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb begin
        stat.done = (state_reg == L_DONE);
        if (neg_reg) begin
            q_sat  = (quo_reg > SAT_NEG_MAG) ? SAT_NEG_MAG : quo_reg;
            result = SAMPLE_W'(~q_sat[SAMPLE_W-1:0] + SAMPLE_W'(1));
        end else begin
            q_sat  = (quo_reg > SAT_POS) ? SAT_POS : quo_reg;
            result = q_sat[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            L_IDLE: begin
                if (ctrl.start) begin
                    neg_reg    <= sample_u[SAMPLE_W-1];
                    mag_reg    <= mag;
                    vol_reg    <= volume;
                    num_reg    <= num;
                    den_reg    <= den;
                    fading_reg <= ctrl.fading;
                end
            end
            L_GAIN: gain_reg <= mag_reg * vol_reg;
            L_MUL: begin
                prod_reg <= gain_reg * num_reg;
                quo_reg  <= gain_reg[GAIN_W-2:Q_FRAC];
            end
            L_PREP: begin
                // the quotient stays below 2^19, so the top part is already a remainder
                rem_reg <= {1'b0, prod_reg[PROD_W-2:PROD_W-1-FRAME_W]};
                dvd_reg <= prod_reg[Q_FRAC+QUO_W-1:Q_FRAC];
                quo_reg <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS - 1);
            end
            L_DIV: begin
                rem_reg <= fits ? (cand - {1'b0, den_reg}) : cand;
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            L_DONE: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/stf_merge.sv -----
// ----------------------------------------------------------------------------
// stf_merge
// joins both lanes and the end flag into the registered result transfer
// ----------------------------------------------------------------------------
`default_nettype none

module stf_merge
    import stf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire lane_stat_t                 left_stat,
    input  wire lane_stat_t                 right_stat,
    input  wire logic signed [SAMPLE_W-1:0] left_res,
    input  wire logic signed [SAMPLE_W-1:0] right_res,
    input  wire logic                       eot,
    input  wire logic                       m_ready,
    output logic                            m_valid,
    output out_frame_t                      m_data,
    output logic                            done,
    output logic                            free
);

    logic       m_valid_reg, m_valid_next;
    out_frame_t data_reg;
    logic       load;

    assign done = left_stat.done & right_stat.done;
    assign free = !m_valid_reg || m_ready;
    assign load = done && free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.left_out     <= left_res;
            data_reg.right_out    <= right_res;
            data_reg.end_of_track <= eot;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ----- sv/stf_checker.sv -----
// ----------------------------------------------------------------------------
// stf_checker
// port-level checks of the silence trim / fade / gain block
// ----------------------------------------------------------------------------
`default_nettype none

`include "silence_trim_fade_gain_macros.svh"

module stf_checker
    import stf_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       cfg_wr_en,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire in_frame_t  s_data,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire out_frame_t m_data
);

    // set once the last frame of the track has gone out, until a register write
    logic ended_reg, ended_next;

    always_comb begin
        ended_next = ended_reg;
        if (cfg_wr_en) begin
            ended_next = 1'b0;
        end else if (m_valid && m_ready && m_data.end_of_track) begin
            ended_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ended_reg <= 1'b0;
        end else begin
            ended_reg <= ended_next;
        end
    end

    property p_reset_idle;
        !aresetn |=> (s_ready && !m_valid);
    endproperty

    property p_result_hold;
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data));
    endproperty

    property p_input_hold;
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data));
    endproperty

    property p_quiet_after_end;
        ended_reg |-> !m_valid;
    endproperty

    `STF_ASSERT(a_reset_state, aclk, p_reset_idle, "reset must leave block idle with no result")

    `STF_ASSERT_RST(a_result_hold, aclk, aresetn, p_result_hold, "stalled result changed")

    `STF_ASSERT_RST(a_input_hold, aclk, aresetn, p_input_hold, "waiting input frame changed")

    `STF_ASSERT_RST(a_no_result_after_end, aclk, aresetn, p_quiet_after_end, "result after end")

endmodule

bind silence_trim_fade_gain stf_checker u_stf_checker (.*);

`default_nettype wire

// ----- test/silence_trim_fade_gain_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silence_trim_fade_gain_tb
// self-checking bench for the stereo silence trimmer with gain and fade-out:
// walks the leading silence search through its threshold and frame-count
// exits, then checks gain, saturation, the fade ramp and the end of track,
// and closes with randomized register settings and sample streams
// ----------------------------------------------------------------------------

module silence_trim_fade_gain_tb;

    import stf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RESULT_TARGET = 1430;    // kept frames over the whole run for the random part to reach
    localparam int IDLE_PCT      = 11;

    // dut ports
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_frame_t             s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_frame_t            m_data;

    // register shadow
    logic [THR_W-1:0]   thr_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic [FRAME_W-1:0] fade_reg;
    logic [FRAME_W-1:0] total_reg;
    logic [VOL_W-1:0]   vol_reg;

    // predicted block state
    bit                        searching;
    logic [SAMPLE_W-1:0]       last_left;
    logic [SAMPLE_W-1:0]       last_right;
    logic [SCAN_W-1:0]         quiet_count;
    logic [POSITION_WIDTH-1:0] out_pos;

    out_frame_t pending_frames[$];
    out_frame_t want;
    out_frame_t got;

    // run statistics
    int  frames_trimmed;
    int  frames_past_end;
    int  frames_faded;
    int  results_due;
    int  results_checked;
    int  mismatches;
    int  cycle_count;
    bit  steady;  // no idling on either side while set

    silence_trim_fade_gain uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // |sample| * volume, then either >> 12 or scaled by the remaining
    // fraction of the fade, truncated toward zero and saturated
    function automatic logic [SAMPLE_W-1:0] gain_fade_sample(
        input logic signed [SAMPLE_W-1:0] s,
        input bit                         fading
    );
        int              sv;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        sv   = s;
        mag  = (sv < 0) ? longint'(-sv) : longint'(sv);
        prod = mag * longint'(vol_reg);
        if (fading) begin
            num = longint'(total_reg) - longint'(out_pos);
            den = (longint'(total_reg) - longint'(fade_reg)) * 4096;
            q   = (prod * num) / den;
        end else begin
            q = prod >> Q_FRAC;
        end
        if (sv < 0) begin
            if (q > 32768) q = 32768;
            return SAMPLE_W'(64'd0 - q);
        end
        if (q > 32767) q = 32767;
        return SAMPLE_W'(q);
    endfunction

    function automatic int sample_step(input logic [SAMPLE_W-1:0] a,
                                       input logic [SAMPLE_W-1:0] b);
        int d;
        d = int'($signed(a)) - int'($signed(b));
        return (d < 0) ? -d : d;
    endfunction

    // advance the shadow state by one accepted frame, queue any result
    function automatic void process_frame(input in_frame_t f);
        out_frame_t o;
        bit         fading;
        if (searching) begin
            if (quiet_count >= scan_reg) begin
                searching = 1'b0;
            end else if (sample_step(f.left_in, last_left) > int'(thr_reg) ||
                         sample_step(f.right_in, last_right) > int'(thr_reg)) begin
                searching = 1'b0;
            end else begin
                last_left   = f.left_in;
                last_right  = f.right_in;
                quiet_count = quiet_count + 1'b1;
                frames_trimmed++;
                return;
            end
        end
        // track over: frame dropped, position holds
        if (CMP_WIDTH'(out_pos) >= CMP_WIDTH'(total_reg)) begin
            frames_past_end++;
            return;
        end
        fading = (total_reg > fade_reg) && (CMP_WIDTH'(out_pos) > CMP_WIDTH'(fade_reg));
        if (fading) frames_faded++;
        o.left_out     = gain_fade_sample(f.left_in, fading);
        o.right_out    = gain_fade_sample(f.right_in, fading);
        o.end_of_track = (CMP_WIDTH'(out_pos) + 1 == CMP_WIDTH'(total_reg));
        pending_frames.push_back(o);
        results_due++;
        out_pos = out_pos + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one register write, shadow updated at the write edge
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_SILENCE_THRESHOLD: thr_reg   = val[THR_W-1:0];
            REG_SCAN_LIMIT:        scan_reg  = val[SCAN_W-1:0];
            REG_FADE_START:        fade_reg  = val[FRAME_W-1:0];
            REG_TOTAL_FRAMES:      total_reg = val[FRAME_W-1:0];
            REG_VOLUME_Q12:        vol_reg   = val[VOL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one input transfer; valid stays up afterwards unless the next call idles
    task automatic send_frame(input in_frame_t f);
        @(negedge aclk);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        process_frame(f);
    endtask

    task automatic send_pair(input int l, input int r);
        in_frame_t f;
        f.left_in  = SAMPLE_W'(l);
        f.right_in = SAMPLE_W'(r);
        send_frame(f);
    endtask

    // stop sending, wait for every queued result, then let trimmed or
    // dropped frames still in flight clear before touching registers
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly full-range samples, with extremes and near-zero values mixed in
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
            1:       return SAMPLE_W'($urandom_range(0, 64) - 32);
            2:       return SAMPLE_W'($urandom_range(0, 1023) - 512);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker: every m_ transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            if (pending_frames.size() == 0) begin
                $error("result transfer with nothing expected: left_out %0d right_out %0d",
                       got.left_out, got.right_out);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                if (got.left_out !== want.left_out) begin
                    $error("left_out: expected %0d, got %0d", want.left_out, got.left_out);
                    mismatches++;
                end
                if (got.right_out !== want.right_out) begin
                    $error("right_out: expected %0d, got %0d", want.right_out, got.right_out);
                    mismatches++;
                end
                if (got.end_of_track !== want.end_of_track) begin
                    $error("end_of_track: expected %0d, got %0d",
                           want.end_of_track, got.end_of_track);
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_frames.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // leading silence: threshold at both extremes, a change exactly at the
    // threshold, and the search ending because the frame count ran out
    task automatic test_silence_search();
        write_reg(REG_SILENCE_THRESHOLD, 32'hFFFF);
        write_reg(REG_SCAN_LIMIT, 32'd8);
        send_pair(0, 0);
        send_pair(-32768, -32768);
        send_pair(32767, 32767);        // full-scale step still silent
        send_pair(-32768, 32767);
        drain_results();
        write_reg(REG_SILENCE_THRESHOLD, 32'd0);
        send_pair(-32768, 32767);       // no change at all
        drain_results();
        write_reg(REG_SILENCE_THRESHOLD, 32'd100);
        send_pair(-32668, 32767);       // step equal to threshold
        send_pair(-32668, 32667);
        send_pair(-32768, 32767);       // count now at the limit
        send_pair(-32768, 32767);       // quiet, but kept: search exhausted
        send_pair(0, 0);                // search over, kept
        drain_results();
    endtask

    // gain extremes and saturation with the fade out of the way
    task automatic test_gain_extremes();
        write_reg(REG_FADE_START, 32'hFFFF_FFFF);
        write_reg(REG_TOTAL_FRAMES, 32'hFFFF_FFFF);  // end not after fade start
        write_reg(REG_VOLUME_Q12, 32'hFFFF);
        send_pair(32767, -32768);
        send_pair(1, -1);
        drain_results();
        write_reg(REG_VOLUME_Q12, 32'd0);
        send_pair(32767, -32768);
        drain_results();
        write_reg(REG_VOLUME_Q12, 32'd1);
        send_pair(4095, -4095);
        drain_results();
        write_reg(REG_VOLUME_Q12, 32'd8192);
        send_pair(16384, -16384);
        send_pair(-16385, 16383);
        drain_results();
    endtask

    // short fade ramp right at the current position, end of track, then
    // frames past the end that must vanish
    task automatic test_fade_window();
        logic [FRAME_W-1:0] base;
        base = FRAME_W'(out_pos);
        write_reg(REG_VOLUME_Q12, 32'd4096);
        write_reg(REG_FADE_START, base + 1);
        write_reg(REG_TOTAL_FRAMES, base + 5);
        repeat (7) send_pair(32767, -32768);
        drain_results();
        // empty track: everything dropped
        write_reg(REG_TOTAL_FRAMES, 32'd0);
        write_reg(REG_FADE_START, 32'd0);
        send_pair(-1, 1);
        drain_results();
    endtask

    // random register settings per segment, each followed by a burst of
    // random frames, sized to reach the track end unless the track is open-ended
    task automatic test_random_segments();
        int                 seg;
        int                 n;
        int                 mode;
        logic [FRAME_W-1:0] fs;
        logic [FRAME_W-1:0] tot;
        in_frame_t          f;
        seg = 0;
        while (results_due < RESULT_TARGET) begin
            drain_results();
            steady = (seg >= 4 && seg < 9);  // one long stretch with no idling
            case ($urandom_range(0, 5))
                0:       write_reg(REG_VOLUME_Q12, 32'd4096);
                1:       write_reg(REG_VOLUME_Q12, 32'd0);
                2:       write_reg(REG_VOLUME_Q12, 32'hFFFF);
                3:       write_reg(REG_VOLUME_Q12, $urandom_range(0, 65535));
                default: write_reg(REG_VOLUME_Q12, $urandom_range(2048, 8192));
            endcase
            // search is over, these must have no effect
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SILENCE_THRESHOLD, $urandom_range(0, 65535));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SCAN_LIMIT, ($urandom_range(0, 3) == 0) ? 32'hFF_FFFF :
                                          $urandom_range(0, 24'hFF_FFFF));
            mode = $urandom_range(0, 3);
            if (mode == 0) begin
                // open-ended track, fade from zero or from a random point
                fs  = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
                tot = 32'hFFFF_FFFF;
                n   = $urandom_range(10, 60);
            end else if (mode == 3) begin
                // end not after fade start: no fade, track still ends
                tot = FRAME_W'(out_pos) + $urandom_range(5, 60);
                fs  = tot + $urandom_range(0, 4);
                n   = int'(tot - FRAME_W'(out_pos)) + $urandom_range(0, 2);
            end else begin
                fs  = FRAME_W'(out_pos) + $urandom_range(0, 30);
                tot = fs + $urandom_range(1, 80);
                n   = int'(tot - FRAME_W'(out_pos)) + $urandom_range(0, 2);
            end
            write_reg(REG_FADE_START, fs);
            write_reg(REG_TOTAL_FRAMES, tot);
            repeat (n) begin
                f.left_in  = random_sample();
                f.right_in = random_sample();
                send_frame(f);
            end
            seg++;
        end
        steady = 1'b0;
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        steady    = 1'b0;

        // reset values of the shadow registers and state
        thr_reg     = RST_THRESHOLD;
        scan_reg    = RST_SCAN_LIMIT;
        fade_reg    = RST_FADE_START;
        total_reg   = RST_TOTAL;
        vol_reg     = RST_VOLUME;
        searching   = 1'b1;
        last_left   = '0;
        last_right  = '0;
        quiet_count = '0;
        out_pos     = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_silence_search();
        test_gain_extremes();
        test_fade_window();
        test_random_segments();

        $display("silence search trimmed %0d frames; %0d results checked, %0d of them faded",
                 frames_trimmed, results_checked, frames_faded);
        $display("%0d frames dropped past end of track, %0d cycles",
                 frames_past_end, cycle_count);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
